>>> rtl/core/klx_pkg.sv
// klx_pkg: shared types, token codes, keyword tables and character classes
// for the keyword lexer stream block; no dependencies
package klx_pkg;

    // token kinds
    localparam logic [2:0] KIND_KEYWORD  = 3'd0;
    localparam logic [2:0] KIND_CONSTANT = 3'd1;
    localparam logic [2:0] KIND_VARIABLE = 3'd2;
    localparam logic [2:0] KIND_SYMBOL   = 3'd3;
    localparam logic [2:0] KIND_OPERATOR = 3'd4;

    localparam int NUM_KEYWORDS = 7;

    // keyword text, zero padded to eight characters
    // order: start end var loop if func main
    localparam logic [7:0] KW_TEXT [0:NUM_KEYWORDS-1][0:7] = '{
        '{"s", "t", "a", "r", "t", 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "o", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [0:NUM_KEYWORDS-1] = '{
        3'd5, 3'd3, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_SYM
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // input character accepted this cycle
        logic rd_en;      // read buffer entry at the emit index
        logic emit_word;  // load one word character into the output register
        logic emit_sym;   // load the pending symbol/operator into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_sep;      // incoming char closes the word
        logic is_punct;    // incoming char is a symbol or operator
        logic word_empty;  // no characters buffered
        logic last_char;   // emit index points at the final character
        logic out_free;    // output register can take a new value this cycle
        logic pend_sym;    // a symbol/operator waits behind the word
    } t_stat;

    function automatic logic is_space(input logic [7:0] c);
        logic r;
        case (c) inside
            8'd32, [8'd9:8'd13]: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic r;
        case (c) inside
            "#", "{", "}", "[", "]", "(", ")", "!": r = 1'b1;
            default:                               r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        logic r;
        case (c) inside
            "-", "+", "*", "/", "%", "=", "|", "&", "<", ">": r = 1'b1;
            default:                                         r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        logic r;
        case (c) inside
            ["0":"9"]: r = 1'b1;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/keyword_lexer_stream.sv
// keyword_lexer_stream: streaming keyword lexer top level
// depends on klx_pkg, klx_ctrl and klx_data
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_text_char
//  out     | output    | o_out_valid/ i_out_ready| o_token_kind, o_value_char,
//          |           |                         | o_keyword_number, o_word_truncated,
//          |           |                         | o_token_end, o_run_last
//
// a word character is written to the buffer (while it has room) and the keyword
// candidate mask is narrowed in the same cycle
// after a closing character is accepted the input stays blocked while the word
// drains: each buffered character is read from the buffer (read state), then
// loaded into the output register (emit state), and a trailing symbol/operator
// is loaded after the final character (symbol state)
// the output register lets a new word be accepted while the last result waits
// a stall on the output holds the sequencer in its emit or symbol state
// synchronous active-low reset clears the word state; the buffer is not cleared
module keyword_lexer_stream #(
    parameter int MAX_WORD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_char,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic [2:0] o_keyword_number,
    output logic       o_word_truncated,
    output logic       o_token_end,
    output logic       o_run_last
);
    import klx_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle / read / emit / symbol
    klx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: buffer, keyword candidates, classification, output register
    klx_data #(
        .MAX_WORD (MAX_WORD)
    ) u_data (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_char      (i_text_char),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_token_kind     (o_token_kind),
        .o_value_char     (o_value_char),
        .o_keyword_number (o_keyword_number),
        .o_word_truncated (o_word_truncated),
        .o_token_end      (o_token_end),
        .o_run_last       (o_run_last)
    );

endmodule

>>> rtl/core/klx_ctrl.sv
// klx_ctrl: sequencer for the keyword lexer
// depends on klx_pkg (state type, command and status structs)
module klx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  klx_pkg::t_stat i_stat,
    output klx_pkg::t_cmd  o_cmd
);
    import klx_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.is_sep && !i_stat.word_empty) begin
                        n_state = S_READ;
                    end else if (i_stat.is_punct) begin
                        n_state = S_SYM;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    if (!i_stat.last_char) begin
                        n_state = S_READ;
                    end else if (i_stat.pend_sym) begin
                        n_state = S_SYM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SYM: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit_word = i_stat.out_free;
            end
            S_SYM: begin
                o_cmd.emit_sym = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/klx_data.sv
// klx_data: word buffer, keyword tracking, classification and output register
// depends on klx_pkg (tables, character classes, command and status structs)
module klx_data #(
    parameter int MAX_WORD = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_text_char,
    input  klx_pkg::t_cmd  i_cmd,
    output klx_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_token_kind,
    output logic [7:0]     o_value_char,
    output logic [2:0]     o_keyword_number,
    output logic           o_word_truncated,
    output logic           o_token_end,
    output logic           o_run_last
);
    import klx_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = $clog2(MAX_WORD);

    logic [7:0]    r_mem [0:MAX_WORD-1];
    logic [7:0]    r_rd_data;
    logic [LW-1:0] r_len,    n_len;
    logic          r_digits, n_digits;
    logic [6:0]    r_cand,   n_cand;
    logic          r_ovf,    n_ovf;
    logic [AW-1:0] r_idx,    n_idx;
    logic [7:0]    r_pend;
    logic          r_pend_sym;

    logic          r_out_valid;
    logic [2:0]    r_kind;
    logic [7:0]    r_value;
    logic [2:0]    r_kwn;
    logic          r_trunc;
    logic          r_end;
    logic          r_last;

    logic          in_sep;
    logic          in_punct;
    logic          room;
    logic          last_char;
    logic          out_free;
    logic          kw_hit;
    logic [2:0]    kw_num;
    logic [2:0]    word_kind;

    assign in_punct  = is_symbol(i_text_char) || is_operator(i_text_char);
    assign in_sep    = is_space(i_text_char) || in_punct;
    assign room      = (r_len != LW'(MAX_WORD));
    assign last_char = ((LW'(r_idx) + LW'(1)) == r_len);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.is_sep     = in_sep;
    assign o_stat.is_punct   = in_punct;
    assign o_stat.word_empty = (r_len == '0);
    assign o_stat.last_char  = last_char;
    assign o_stat.out_free   = out_free;
    assign o_stat.pend_sym   = r_pend_sym;

    // first keyword still a candidate whose length equals the word length
    always_comb begin
        kw_hit = 1'b0;
        kw_num = 3'd0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (r_cand[k] && (r_len == LW'(KW_LEN[k]))) begin
                kw_hit = 1'b1;
                kw_num = 3'(k);
            end
        end
        if (kw_hit && !r_ovf) begin
            word_kind = KIND_KEYWORD;
        end else if (r_digits) begin
            word_kind = KIND_CONSTANT;
        end else begin
            word_kind = KIND_VARIABLE;
        end
    end

    // word state update
    always_comb begin
        n_len    = r_len;
        n_digits = r_digits;
        n_cand   = r_cand;
        n_ovf    = r_ovf;
        n_idx    = r_idx;
        if (i_cmd.take && !in_sep) begin
            if (!is_digit(i_text_char)) begin
                n_digits = 1'b0;
            end
            if (room) begin
                for (int k = 0; k < NUM_KEYWORDS; k++) begin
                    if ((r_len >= LW'(KW_LEN[k])) ||
                        (KW_TEXT[k][r_len[2:0]] != i_text_char)) begin
                        n_cand[k] = 1'b0;
                    end
                end
                n_len = r_len + LW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.emit_word) begin
            if (last_char) begin
                n_idx    = '0;
                n_len    = '0;
                n_digits = 1'b1;
                n_cand   = '1;
                n_ovf    = 1'b0;
            end else begin
                n_idx = r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_digits   <= 1'b1;
            r_cand     <= '1;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_pend_sym <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_digits <= n_digits;
            r_cand   <= n_cand;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            if (i_cmd.take) begin
                r_pend_sym <= in_punct;
            end else if (i_cmd.emit_sym) begin
                r_pend_sym <= 1'b0;
            end
        end
    end

    // pending character, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend <= i_text_char;
        end
    end

    // word buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !in_sep && room) begin
            r_mem[r_len[AW-1:0]] <= i_text_char;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_word || i_cmd.emit_sym) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_word) begin
            r_kind  <= word_kind;
            r_value <= r_rd_data;
            r_kwn   <= (word_kind == KIND_KEYWORD) ? kw_num : 3'd0;
            r_trunc <= r_ovf;
            r_end   <= last_char;
            r_last  <= last_char && !r_pend_sym;
        end else if (i_cmd.emit_sym) begin
            r_kind  <= is_symbol(r_pend) ? KIND_SYMBOL : KIND_OPERATOR;
            r_value <= r_pend;
            r_kwn   <= 3'd0;
            r_trunc <= 1'b0;
            r_end   <= 1'b1;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_token_kind     = r_kind;
    assign o_value_char     = r_value;
    assign o_keyword_number = r_kwn;
    assign o_word_truncated = r_trunc;
    assign o_token_end      = r_end;
    assign o_run_last       = r_last;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_WORD))
        else $error("word length beyond buffer size");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_word || i_cmd.emit_sym) |-> out_free)
        else $error("output register overwritten before taken");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_word |-> (r_len != '0))
        else $error("word emit with empty buffer");

    a_word_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_word && last_char) |=> (r_len == '0 && r_idx == '0))
        else $error("word not cleared after final character");

    a_take_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !(i_cmd.emit_word || i_cmd.emit_sym || i_cmd.rd_en))
        else $error("input taken during word emission");
`endif

endmodule
